// ===== rtl/scanpf_pkg.sv =====
package scanpf_pkg;

  // Field widths of the ports
  localparam int unsigned CoordW   = 16;
  localparam int unsigned PixW     = 11;
  localparam int unsigned RowW     = 10;
  localparam int unsigned VidxW    = 8;
  localparam int unsigned VcntW    = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // Defaults for the top level parameters
  localparam int unsigned DefMaxVertices  = 256;
  localparam int unsigned DefMaxCrossings = 32;

  // Spans kept per row
  localparam int unsigned MaxSpans = 16;
  localparam int unsigned SpanCntW = 5;

  // Divider quotient and operand widths
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned QuoW  = 16;

  // Reset values of the configuration registers
  localparam logic [PixW-1:0]  WidthRst  = 11'd260;
  localparam logic [PixW-1:0]  HeightRst = 11'd192;
  localparam logic [VcntW-1:0] VcntRst   = 9'd0;
  localparam logic             FillRst   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_VCOUNT = 2'd2,
    CFG_FILL   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_EDGE,
    ST_MUL,
    ST_CALC,
    ST_INS,
    ST_NEXT,
    ST_SPAN_S,
    ST_SPAN_E
  } fill_state_e;

  typedef enum logic [1:0] {
    EU_IDLE,
    EU_PREP,
    EU_DIV,
    EU_DONE
  } eu_phase_e;

  // Edge unit handshake toward the sequencer
  typedef struct packed {
    logic                    done;
    logic signed [DiffW:0]   quot;
  } eu_status_t;

  // Crossing in 1/16 pixel (already ceil-rounded) to pixel ceil(x - 0.5)
  function automatic logic signed [12:0] pixel_of(input logic signed [CoordW-1:0] c);
    logic signed [CoordW:0] t;
    t = 17'(c) + 17'sd7;
    return t[CoordW:4];
  endfunction

  // Clamp a pixel to [lo, w]
  function automatic logic [PixW-1:0] clamp_pix(input logic signed [12:0] p,
                                                input logic [PixW-1:0] lo,
                                                input logic [PixW-1:0] w);
    logic signed [12:0] lo_s;
    logic signed [12:0] w_s;
    lo_s = $signed({2'b00, lo});
    w_s  = $signed({2'b00, w});
    if (p < lo_s) return lo;
    else if (p > w_s) return w;
    else return p[PixW-1:0];
  endfunction

endpackage

// ===== rtl/scanpf_ram.sv =====
module scanpf_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/scanpf_edge_unit.sv =====
module scanpf_edge_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [scanpf_pkg::DiffW-1:0]   dy_i,
  input  logic signed [scanpf_pkg::DiffW-1:0]   dx_i,
  input  logic signed [scanpf_pkg::DiffW-1:0]   dn_i,
  output scanpf_pkg::eu_status_t                status_o
);
  import scanpf_pkg::*;

  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned CntW  = $clog2(QuoW + 1);

  eu_phase_e phase_q, phase_d;

  logic signed [ProdW-1:0] prod_q;
  logic [QuoW-1:0]         dmag_q;
  logic                    dneg_q;
  logic                    neg_q;
  logic [QuoW-1:0]         rem_q;
  logic [QuoW-1:0]         low_q;
  logic [CntW-1:0]         cnt_q;

  logic [ProdW-1:0]        prod_abs;
  logic [QuoW+1:0]         trial;
  logic [DiffW-1:0]        dn_abs;
  logic signed [DiffW:0]   q_ext;

  assign prod_abs = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
  assign dn_abs   = dn_i[DiffW-1] ? DiffW'(-dn_i) : DiffW'(dn_i);
  assign trial    = {1'b0, rem_q, low_q[QuoW-1]} - {2'b00, dmag_q};
  assign q_ext    = $signed({2'b00, low_q});

  // Sequence the phases
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      EU_IDLE: if (start_i) phase_d = EU_PREP;
      EU_PREP: phase_d = EU_DIV;
      EU_DIV:  if (cnt_q == CntW'(1)) phase_d = EU_DONE;
      EU_DONE: phase_d = EU_IDLE;
      default: phase_d = EU_IDLE;
    endcase
  end

  // Drive the result: ceiling of the signed quotient
  always_comb begin
    status_o.done = (phase_q == EU_DONE);
    if (neg_q) status_o.quot = -q_ext;
    else       status_o.quot = q_ext + ((rem_q != '0) ? 18'sd1 : 18'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= EU_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Multiply, then restoring division one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    case (phase_q)
      EU_IDLE: begin
        if (start_i) begin
          prod_q <= dy_i * dx_i;
          dmag_q <= dn_abs[QuoW-1:0];
          dneg_q <= dn_i[DiffW-1];
        end
      end
      EU_PREP: begin
        neg_q <= prod_q[ProdW-1] ^ dneg_q;
        rem_q <= prod_abs[2*QuoW-1:QuoW];
        low_q <= prod_abs[QuoW-1:0];
        cnt_q <= CntW'(QuoW);
      end
      EU_DIV: begin
        if (!trial[QuoW+1]) begin
          rem_q <= trial[QuoW-1:0];
          low_q <= {low_q[QuoW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[QuoW-2:0], low_q[QuoW-1]};
          low_q <= {low_q[QuoW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CntW'(1);
      end
      default: begin
      end
    endcase
  end

  // Result pulses for one cycle and only after a division ran
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.done |=> !status_o.done)
    else $error("edge unit done held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.done |-> $past(phase_q) == EU_DIV)
    else $error("edge unit done without division");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == EU_DIV |-> cnt_q != '0)
    else $error("edge unit step count underflow");

endmodule

// ===== rtl/scanline_polygon_span_fill.sv =====
// Even-odd scanline polygon rasterizer. A load command (cmd_i = 0) writes one
// Q12.4 vertex and returns one acknowledge result the next cycle; a render
// command (cmd_i = 1) walks every edge of the closed polygon against the row
// centre and returns one span per crossing pair, up to sixteen, each on the
// result ports for one cycle marked by span_valid_o, the final one with last_o.
// Results cannot be stalled: the receiver must take every strobe. An empty or
// rejected row returns one result flagged row_empty_o. While a row is busy, each
// crossing edge goes through the shared multiply and bit-serial divide unit and
// is then inserted into the sorted crossing store (not once the store is full),
// and the spans are read out pairwise after the last edge; loads and rejected
// rows never raise busy and answer on the next cycle.
module scanline_polygon_span_fill #(
  parameter int unsigned MAX_VERTICES  = scanpf_pkg::DefMaxVertices,
  parameter int unsigned MAX_CROSSINGS = scanpf_pkg::DefMaxCrossings
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd_i,
  input  logic [scanpf_pkg::VidxW-1:0]      vertex_index_i,
  input  logic signed [scanpf_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [scanpf_pkg::CoordW-1:0] vertex_y_i,
  input  logic [scanpf_pkg::RowW-1:0]       row_y_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [scanpf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [scanpf_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                              span_valid_o,
  output logic [scanpf_pkg::PixW-1:0]       span_start_o,
  output logic [scanpf_pkg::PixW-1:0]       span_end_o,
  output logic                              span_fill_o,
  output logic                              row_empty_o,
  output logic                              crossing_overflow_o,
  output logic                              last_o
);
  import scanpf_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CAW = (MAX_CROSSINGS > 1) ? $clog2(MAX_CROSSINGS) : 1;
  localparam int unsigned CNW = $clog2(MAX_CROSSINGS + 1);
  localparam int unsigned VW  = 2 * CoordW;

  fill_state_e state_q, state_d;

  // Configuration
  logic [PixW-1:0]  width_q, height_q;
  logic [VcntW-1:0] vcnt_q;
  logic             fill_q;

  // Row working registers
  logic [RowW-1:0]          y_q;
  logic [NW-1:0]            n_q;
  logic [NW-1:0]            i_q;
  logic [VW-1:0]            first_q, prev_q, cur_q;
  logic signed [DiffW-1:0]  dy_q, dx_q, dn_q;
  logic [CNW-1:0]           nx_q, pos_q;
  logic signed [CoordW-1:0] v_q;
  logic                     ovf_q;
  logic [SpanCntW-1:0]      k_q, pairs_q;
  logic [PixW-1:0]          s_q;

  // Result registers
  logic            out_valid_q, out_empty_q, out_ovf_q, out_last_q;
  logic [PixW-1:0] out_start_q, out_end_q;

  // Memory ports
  logic             vt_we, vt_re;
  logic [AW-1:0]    vt_raddr;
  logic [VW-1:0]    vt_rdata;
  logic             xs_we, xs_re;
  logic [CAW-1:0]   xs_waddr, xs_raddr;
  logic [CoordW-1:0] xs_wdata, xs_rdata;

  eu_status_t eu_st;
  logic       eu_start;

  logic                     accept;
  logic [NW-1:0]            n_clip;
  logic                     row_reject;
  logic [VW-1:0]            cur;
  logic signed [CoordW-1:0] x1, y1, x2, y2, lo, hi;
  logic signed [DiffW-1:0]  cy;
  logic                     hit;
  logic signed [CoordW-1:0] cross_x;
  logic signed [CoordW-1:0] rd_x;
  logic [PixW-1:0]          e_pix;
  logic                     last_span;
  logic [CNW-1:0]           half_nx;
  logic                     edges_done;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign n_clip     = (32'(vcnt_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcnt_q);
  assign row_reject = ({1'b0, row_y_i} >= height_q) || (n_clip < NW'(3));

  // Edge geometry: previous vertex to current one, wrapping to vertex zero
  assign cur = (i_q + NW'(1) == n_q) ? first_q : vt_rdata;
  assign x1  = $signed(prev_q[CoordW-1:0]);
  assign y1  = $signed(prev_q[VW-1:CoordW]);
  assign x2  = $signed(cur[CoordW-1:0]);
  assign y2  = $signed(cur[VW-1:CoordW]);
  assign lo  = (y1 < y2) ? y1 : y2;
  assign hi  = (y1 < y2) ? y2 : y1;
  assign cy  = $signed({3'b000, y_q, 4'h8});
  assign hit = (y1 != y2) && (cy >= DiffW'(lo)) && (cy < DiffW'(hi));

  assign cross_x    = x1 + CoordW'(eu_st.quot);
  assign rd_x       = $signed(xs_rdata);
  assign e_pix      = clamp_pix(pixel_of(rd_x), s_q, width_q);
  assign last_span  = (k_q + SpanCntW'(1) == pairs_q);
  assign half_nx    = nx_q >> 1;
  assign edges_done = (i_q + NW'(1) == n_q);
  assign eu_start   = (state_q == ST_MUL);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept && cmd_i == CMD_RENDER && !row_reject) state_d = ST_FIRST;
      ST_FIRST:  state_d = ST_EDGE;
      ST_EDGE:   state_d = hit ? ST_MUL : ST_NEXT;
      ST_MUL:    state_d = ST_CALC;
      ST_CALC: begin
        if (eu_st.done) state_d = (32'(nx_q) >= MAX_CROSSINGS) ? ST_NEXT : ST_INS;
      end
      ST_INS: begin
        if (pos_q == '0 || rd_x <= v_q) state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (edges_done) state_d = (nx_q < CNW'(2)) ? ST_IDLE : ST_SPAN_S;
        else            state_d = ST_EDGE;
      end
      ST_SPAN_S: state_d = ST_SPAN_E;
      ST_SPAN_E: state_d = last_span ? ST_IDLE : ST_SPAN_S;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    vt_we    = 1'b0;
    vt_re    = 1'b0;
    vt_raddr = '0;
    xs_we    = 1'b0;
    xs_waddr = '0;
    xs_wdata = '0;
    xs_re    = 1'b0;
    xs_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        vt_we = accept && cmd_i == CMD_LOAD && 32'(vertex_index_i) < MAX_VERTICES;
        vt_re = 1'b1;
      end
      ST_FIRST: begin
        vt_re    = 1'b1;
        vt_raddr = AW'(1);
      end
      ST_CALC: begin
        xs_re    = 1'b1;
        xs_raddr = CAW'(nx_q - CNW'(1));
      end
      ST_INS: begin
        xs_we = 1'b1;
        xs_waddr = CAW'(pos_q);
        if (pos_q != '0 && rd_x > v_q) begin
          xs_wdata = xs_rdata;
          xs_re    = 1'b1;
          xs_raddr = CAW'(pos_q - CNW'(2));
        end else begin
          xs_wdata = v_q;
        end
      end
      ST_NEXT: begin
        vt_re    = 1'b1;
        vt_raddr = AW'(i_q + NW'(2));
        xs_re    = 1'b1;
      end
      ST_SPAN_S: begin
        xs_re    = 1'b1;
        xs_raddr = CAW'({k_q, 1'b1});
      end
      ST_SPAN_E: begin
        xs_re    = 1'b1;
        xs_raddr = CAW'({k_q + SpanCntW'(1), 1'b0});
      end
      default: begin
      end
    endcase
  end

  scanpf_ram #(.Depth(MAX_VERTICES), .Width(VW)) u_vtx (
    .clk_i   (clk_i),
    .we_i    (vt_we),
    .waddr_i (AW'(vertex_index_i)),
    .wdata_i ({vertex_y_i, vertex_x_i}),
    .re_i    (vt_re),
    .raddr_i (vt_raddr),
    .rdata_o (vt_rdata)
  );

  scanpf_ram #(.Depth(MAX_CROSSINGS), .Width(CoordW)) u_xing (
    .clk_i   (clk_i),
    .we_i    (xs_we),
    .waddr_i (xs_waddr),
    .wdata_i (xs_wdata),
    .re_i    (xs_re),
    .raddr_i (xs_raddr),
    .rdata_o (xs_rdata)
  );

  scanpf_edge_unit u_eu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (eu_start),
    .dy_i     (dy_q),
    .dx_i     (dx_q),
    .dn_i     (dn_q),
    .status_o (eu_st)
  );

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WidthRst;
      height_q    <= HeightRst;
      vcnt_q      <= VcntRst;
      fill_q      <= FillRst;
      out_valid_q <= 1'b0;
      nx_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          CFG_VCOUNT: vcnt_q   <= cfg_data_i[VcntW-1:0];
          CFG_FILL:   fill_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          nx_q <= '0;
          if (accept && (cmd_i == CMD_LOAD || row_reject)) out_valid_q <= 1'b1;
        end
        ST_INS: begin
          if (pos_q == '0 || rd_x <= v_q) nx_q <= nx_q + CNW'(1);
        end
        ST_NEXT: begin
          if (edges_done && nx_q < CNW'(2)) out_valid_q <= 1'b1;
        end
        ST_SPAN_E: out_valid_q <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Row datapath and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        y_q         <= row_y_i;
        n_q         <= n_clip;
        ovf_q       <= 1'b0;
        out_start_q <= '0;
        out_end_q   <= '0;
        out_ovf_q   <= 1'b0;
        out_last_q  <= 1'b1;
        out_empty_q <= (cmd_i == CMD_RENDER);
      end
      ST_FIRST: begin
        first_q <= vt_rdata;
        prev_q  <= vt_rdata;
        i_q     <= '0;
      end
      ST_EDGE: begin
        cur_q <= cur;
        dy_q  <= cy - DiffW'(y1);
        dx_q  <= DiffW'(x2) - DiffW'(x1);
        dn_q  <= DiffW'(y2) - DiffW'(y1);
      end
      ST_CALC: begin
        if (eu_st.done) begin
          v_q   <= cross_x;
          pos_q <= nx_q;
          if (32'(nx_q) >= MAX_CROSSINGS) ovf_q <= 1'b1;
        end
      end
      ST_INS: begin
        if (pos_q != '0 && rd_x > v_q) pos_q <= pos_q - CNW'(1);
      end
      ST_NEXT: begin
        prev_q <= cur_q;
        i_q    <= i_q + NW'(1);
        k_q    <= '0;
        if (32'(half_nx) > MaxSpans) begin
          pairs_q <= SpanCntW'(MaxSpans);
          ovf_q   <= 1'b1;
        end else begin
          pairs_q <= SpanCntW'(half_nx);
        end
        out_start_q <= '0;
        out_end_q   <= '0;
        out_empty_q <= 1'b1;
        out_ovf_q   <= 1'b0;
        out_last_q  <= 1'b1;
      end
      ST_SPAN_S: begin
        s_q <= clamp_pix(pixel_of(rd_x), '0, width_q);
      end
      ST_SPAN_E: begin
        out_start_q <= s_q;
        out_end_q   <= e_pix;
        out_empty_q <= 1'b0;
        out_ovf_q   <= ovf_q;
        out_last_q  <= last_span;
        k_q         <= k_q + SpanCntW'(1);
      end
      default: begin
      end
    endcase
  end

  assign span_valid_o        = out_valid_q;
  assign span_start_o        = out_start_q;
  assign span_end_o          = out_end_q;
  assign span_fill_o         = fill_q;
  assign row_empty_o         = out_empty_q;
  assign crossing_overflow_o = out_ovf_q;
  assign last_o              = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o && row_empty_o |-> last_o && !crossing_overflow_o)
    else $error("empty row result not final");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nx_q) <= MAX_CROSSINGS)
    else $error("crossing count beyond store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eu_st.done |-> state_q == ST_CALC)
    else $error("edge result outside calc state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o && !row_empty_o |-> span_start_o <= span_end_o)
    else $error("span ends before it starts");

endmodule

// ===== tb/scanpf_span_checker.sv =====
`timescale 1ns / 100ps

module scanpf_span_checker
  import scanpf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     cmd_i,
  input  logic [VidxW-1:0]         vertex_index_i,
  input  logic signed [CoordW-1:0] vertex_x_i,
  input  logic signed [CoordW-1:0] vertex_y_i,
  input  logic [RowW-1:0]          row_y_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     span_valid_o,
  input  logic [PixW-1:0]          span_start_o,
  input  logic [PixW-1:0]          span_end_o,
  input  logic                     span_fill_o,
  input  logic                     row_empty_o,
  input  logic                     crossing_overflow_o,
  input  logic                     last_o,
  output int                       errors_o,
  output int                       pending_o,
  output int                       spans_seen_o,
  output int                       overflow_rows_o
);

  typedef struct {
    logic [PixW-1:0] first_px;
    logic [PixW-1:0] end_px;
    logic            fill;
    logic            empty;
    logic            ovf;
    logic            last;
  } span_t;

  span_t              span_q[$];
  logic signed [15:0] vtx_x[256];
  logic signed [15:0] vtx_y[256];
  logic [PixW-1:0]    width_q;
  logic [PixW-1:0]    height_q;
  logic [VcntW-1:0]   vcount_q;
  logic               fill_q;

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  task automatic push_span(input int s, input int e, input bit empty, input bit ovf,
                           input bit last);
    span_t r;
    r.first_px = s[PixW-1:0];
    r.end_px   = e[PixW-1:0];
    r.fill     = fill_q;
    r.empty    = empty;
    r.ovf      = ovf;
    r.last     = last;
    span_q.push_back(r);
  endtask

  // Ceil of a pixel crossing shifted by half a pixel
  function automatic int px_of(input int c);
    int v;
    int q;
    v = c - 8;
    q = v / 16;
    if ((v % 16) != 0 && v > 0) q++;
    return q;
  endfunction

  // Walk the closed polygon against the row centre and build the span list
  task automatic predict_row(input int y);
    int n, cy, nx, i, j, x1, y1, x2, y2, lo, hi, k, m, v, pairs, s, e, w;
    longint num, den, q;
    bit ovf;
    int xs[32];
    n   = (vcount_q > 256) ? 256 : int'(vcount_q);
    nx  = 0;
    ovf = 1'b0;
    if (y >= int'(height_q) || n < 3) begin
      push_span(0, 0, 1'b1, 1'b0, 1'b1);
      return;
    end
    cy = y * 16 + 8;
    for (i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      x1 = vtx_x[i];
      y1 = vtx_y[i];
      x2 = vtx_x[j];
      y2 = vtx_y[j];
      lo = (y1 < y2) ? y1 : y2;
      hi = (y1 < y2) ? y2 : y1;
      if (y1 == y2) continue;
      if (!(cy >= lo && cy < hi)) continue;
      num = longint'(cy - y1) * longint'(x2 - x1);
      den = longint'(y2 - y1);
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (nx >= 32) begin
        ovf = 1'b1;
        continue;
      end
      q = num / den;
      if ((num % den) != 0 && num > 0) q++;
      xs[nx] = x1 + int'(q);
      nx++;
    end
    if (nx < 2) begin
      push_span(0, 0, 1'b1, 1'b0, 1'b1);
      return;
    end
    // Sort crossings ascending
    for (k = 1; k < nx; k++) begin
      v = xs[k];
      m = k - 1;
      while (m >= 0 && xs[m] > v) begin
        xs[m + 1] = xs[m];
        m--;
      end
      xs[m + 1] = v;
    end
    pairs = nx / 2;
    if (pairs > MaxSpans) begin
      pairs = MaxSpans;
      ovf   = 1'b1;
    end
    if (ovf) overflow_rows_o++;
    w = int'(width_q);
    for (k = 0; k < pairs; k++) begin
      s = px_of(xs[2 * k]);
      e = px_of(xs[2 * k + 1]);
      if (s < 0) s = 0;
      if (s > w) s = w;
      if (e > w) e = w;
      if (e < s) e = s;
      push_span(s, e, 1'b0, ovf, k + 1 == pairs);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    span_t r;
    if (!rst_ni) begin
      width_q         = WidthRst;
      height_q        = HeightRst;
      vcount_q        = VcntRst;
      fill_q          = FillRst;
      errors_o        = 0;
      pending_o       <= 0;
      spans_seen_o    = 0;
      overflow_rows_o = 0;
      span_q.delete();
    end else begin
      // Compare each result transfer with the oldest expectation
      if (span_valid_o) begin
        spans_seen_o++;
        if (span_q.size() == 0) begin
          report("unexpected result, span_start", span_start_o, 0);
        end else begin
          r = span_q.pop_front();
          if (span_start_o !== r.first_px) report("span_start", span_start_o, r.first_px);
          if (span_end_o !== r.end_px) report("span_end", span_end_o, r.end_px);
          if (span_fill_o !== r.fill) report("span_fill", span_fill_o, r.fill);
          if (row_empty_o !== r.empty) report("row_empty", row_empty_o, r.empty);
          if (crossing_overflow_o !== r.ovf)
            report("crossing_overflow", crossing_overflow_o, r.ovf);
          if (last_o !== r.last) report("last", last_o, r.last);
        end
      end
      // Track register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_WIDTH:  width_q  = cfg_data_i;
          CFG_HEIGHT: height_q = cfg_data_i;
          CFG_VCOUNT: vcount_q = cfg_data_i[VcntW-1:0];
          CFG_FILL:   fill_q   = cfg_data_i[0];
          default: ;
        endcase
      end
      // Predict the results of an accepted command
      if (start && !busy) begin
        if (cmd_e'(cmd_i) == CMD_LOAD) begin
          vtx_x[vertex_index_i] = vertex_x_i;
          vtx_y[vertex_index_i] = vertex_y_i;
          push_span(0, 0, 1'b0, 1'b0, 1'b1);
        end else begin
          predict_row(int'(row_y_i));
        end
      end
      pending_o <= span_q.size();
    end
  end

endmodule

// ===== tb/tb_scanline_polygon_span_fill.sv =====
`timescale 1ns / 100ps

module tb_scanline_polygon_span_fill;
  import scanpf_pkg::*;

  localparam int IdleLimit = 200000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic                     cmd_i;
  logic [VidxW-1:0]         vertex_index_i;
  logic signed [CoordW-1:0] vertex_x_i;
  logic signed [CoordW-1:0] vertex_y_i;
  logic [RowW-1:0]          row_y_i;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  logic                     span_valid_o;
  logic [PixW-1:0]          span_start_o;
  logic [PixW-1:0]          span_end_o;
  logic                     span_fill_o;
  logic                     row_empty_o;
  logic                     crossing_overflow_o;
  logic                     last_o;
  int                       errors, pending, spans_seen, overflow_rows;
  int                       cmds_sent;
  int                       idle_cycles = 0;
  bit                       gaps_on;
  int                       cur_w, cur_h;

  scanline_polygon_span_fill uut (.*);
  scanpf_span_checker chk (
    .*,
    .errors_o        (errors),
    .pending_o       (pending),
    .spans_seen_o    (spans_seen),
    .overflow_rows_o (overflow_rows)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: end the run after a long stretch with no transfer at all
  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || span_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("tb_scanline_polygon_span_fill: FAIL");
      $finish;
    end
  end

  // Write one register; valid stays high for a back-to-back write
  task automatic write_reg(input cfg_idx_e idx, input int data);
    if (gaps_on && $urandom_range(99) < 29) begin
      cfg_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_WIDTH) cur_w = data;
    if (idx == CFG_HEIGHT) cur_h = data;
  endtask

  // Issue one command; start stays high for a back-to-back command
  task automatic issue(input cmd_e cmd, input int idx, input int x, input int y,
                       input int row);
    if (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start          <= 1'b1;
    cmd_i          <= cmd;
    vertex_index_i <= idx[VidxW-1:0];
    vertex_x_i     <= x[CoordW-1:0];
    vertex_y_i     <= y[CoordW-1:0];
    row_y_i        <= row[RowW-1:0];
    do @(posedge clk_i); while (busy);
    cmds_sent++;
  endtask

  task automatic load_vtx(input int idx, input int x, input int y);
    issue(CMD_LOAD, idx, x, y, $urandom_range(0, 1023));
  endtask

  task automatic render(input int row);
    issue(CMD_RENDER, $urandom_range(0, 255), $urandom, $urandom, row);
  endtask

  // Drop both valids and wait until every expected result has come back
  task automatic drain();
    start       <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h, input int n, input int f);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_VCOUNT, n);
    write_reg(CFG_FILL, f);
    cfg_valid_i <= 1'b0;
  endtask

  // Coordinate near the visible frame, or anywhere in range now and then
  function automatic int pick_coord(input int lim);
    if ($urandom_range(99) < 12) return int'($signed(16'($urandom)));
    return ($urandom_range(0, lim + 80) - 40) * 16 + $urandom_range(0, 15);
  endfunction

  function automatic int pick_row();
    if ($urandom_range(99) < 25) return $urandom_range(0, 1023);
    return $urandom_range(0, cur_h + 4);
  endfunction

  initial begin
    int n, w, h, k, p;
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = CMD_LOAD;
    vertex_index_i = '0;
    vertex_x_i     = '0;
    vertex_y_i     = '0;
    row_y_i        = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_WIDTH;
    cfg_data_i     = '0;
    cmds_sent      = 0;
    gaps_on        = 1'b1;
    cur_w          = 260;
    cur_h          = 192;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no vertices in use gives an empty row
    render(10);
    drain();

    // Full-range square, narrowest image, clear fill
    set_frame(1, 1024, 4, 0);
    load_vtx(0, -32768, -32768);
    load_vtx(1, 32767, -32768);
    load_vtx(2, 32767, 32767);
    load_vtx(3, -32768, 32767);
    render(0);
    render(1023);
    drain();

    // Triangle with a sliver tip, widest image, single row
    set_frame(1024, 1, 3, 1);
    load_vtx(0, 16 * 5, 0);
    load_vtx(1, 16 * 5 + 3, 16 * 3);
    load_vtx(2, 16 * 2000 / 2, 16 * 200);
    render(0);
    render(1);
    render(1023);
    drain();

    // Reshaped triangle, rows on a vertex, below and above, clamped on both sides
    set_frame(300, 400, 3, 1);
    load_vtx(2, -16 * 100, 16 * 200);
    load_vtx(1, 16 * 900, 16 * 3);
    render(3);
    render(100);
    render(199);
    render(200);
    render(399);
    drain();

    // Zigzag: more crossings than the store holds
    set_frame(1024, 1024, 40, 1);
    gaps_on = 1'b0;
    for (k = 0; k < 40; k++) load_vtx(k, k * 64 + 3, (k % 2) ? 16 * 1000 : 0);
    render(500);
    render(1010);
    gaps_on = 1'b1;
    drain();

    // Random polygons, mostly well formed, with stray loads between rows
    for (p = 0; p < 4; p++) begin
      w = ($urandom_range(3) == 0) ? (($urandom_range(1)) ? 1 : 1024) : $urandom_range(1, 1024);
      h = ($urandom_range(3) == 0) ? 1024 : $urandom_range(1, 1024);
      n = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      gaps_on = (p != 2);
      set_frame(w, h, n, $urandom_range(1));
      for (k = 0; k < n; k++) load_vtx(k, pick_coord(w), pick_coord(h));
      for (k = 0; k < 10; k++) begin
        if ($urandom_range(99) < 20)
          load_vtx($urandom_range(0, 255), pick_coord(w), pick_coord(h));
        else
          render(pick_row());
      end
      drain();
    end
    gaps_on = 1'b1;

    $display("covered %0d commands and %0d result transfers", cmds_sent, spans_seen);
    $display("rows with crossing overflow: %0d", overflow_rows);
    if (errors == 0) begin
      $display("tb_scanline_polygon_span_fill: PASS");
    end else begin
      $display("tb_scanline_polygon_span_fill: FAIL");
    end
    $finish;
  end

endmodule
